// ===== hdl/b64_pkg.sv =====
package b64_pkg;

  localparam int unsigned LineLenWidth = 10;
  localparam int unsigned GroupSlots   = 4;

  localparam logic [1:0] ActData = 2'd0;
  localparam logic [1:0] ActLast = 2'd1;
  localparam logic [1:0] ActEnd  = 2'd2;

  localparam logic [7:0] CharNl  = 8'h0A;
  localparam logic [7:0] CharPad = 8'h3D;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [LineLenWidth-1:0] line_length;
  } cfg_item_t;

  // Characters an item produces before line wrapping is applied.
  typedef struct packed {
    logic [GroupSlots-1:0][7:0] chars;
    logic [2:0]                 count;
    logic                       closes_msg;
  } job_t;

  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = 8'h41 + w;
    end else if (v < 6'd52) begin
      c = 8'h61 + (w - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + (w - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hdl/b64_stream_if.sv =====
interface b64_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/b64_group_enc.sv =====
module b64_group_enc (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64_stream_if.sink    in_i,
  input  logic          pop_i,
  output b64_pkg::job_t job_o,
  output logic          job_valid_o
);
  import b64_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [3:0] lo_q, lo_d;
  logic       job_valid_q, job_valid_d;
  job_t       job_q, job_d;
  logic       take, fin, accept;
  logic [7:0] b;
  logic [1:0] slot;

  assign in_i.ready  = !job_valid_q || pop_i;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = in_i.payload.data_byte;
  assign take        = (in_i.payload.action == ActData) || (in_i.payload.action == ActLast);
  assign fin         = (in_i.payload.action == ActLast) || (in_i.payload.action == ActEnd);
  assign job_o       = job_q;
  assign job_valid_o = job_valid_q;

  always_comb begin
    job_d.chars      = '0;
    job_d.count      = 3'd0;
    job_d.closes_msg = fin;
    phase_d          = phase_q;
    lo_d             = lo_q;
    slot             = 2'd0;
    if (take) begin
      unique case (phase_q)
        2'd0: begin
          job_d.chars[0] = b64_char(b[7:2]);
          job_d.count    = 3'd1;
          lo_d           = {2'b00, b[1:0]};
          phase_d        = 2'd1;
        end
        2'd1: begin
          job_d.chars[0] = b64_char({lo_q[1:0], b[7:4]});
          job_d.count    = 3'd1;
          lo_d           = b[3:0];
          phase_d        = 2'd2;
        end
        2'd2: begin
          job_d.chars[0] = b64_char({lo_q, b[7:6]});
          job_d.chars[1] = b64_char(b[5:0]);
          job_d.count    = 3'd2;
          lo_d           = 4'd0;
          phase_d        = 2'd0;
        end
        default: begin
        end
      endcase
    end
    if (fin) begin
      slot = job_d.count[1:0];
      unique case (phase_d)
        2'd1: begin
          job_d.chars[slot]        = b64_char({lo_d[1:0], 4'b0000});
          job_d.chars[slot + 2'd1] = CharPad;
          job_d.chars[slot + 2'd2] = CharPad;
          job_d.count              = job_d.count + 3'd3;
        end
        2'd2: begin
          job_d.chars[slot]        = b64_char({lo_d, 2'b00});
          job_d.chars[slot + 2'd1] = CharPad;
          job_d.count              = job_d.count + 3'd2;
        end
        default: begin
        end
      endcase
      phase_d = 2'd0;
      lo_d    = 4'd0;
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    if (pop_i) begin
      job_valid_d = 1'b0;
    end
    // An unused action code is taken but leaves nothing to emit.
    if (accept && (take || fin)) begin
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      lo_q        <= 4'd0;
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        lo_q    <= lo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (take || fin)) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== hdl/b64_line_fmt.sv =====
module b64_line_fmt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  b64_pkg::job_t                    job_i,
  input  logic                             job_valid_i,
  input  logic [b64_pkg::LineLenWidth-1:0] line_len_i,
  output logic                             pop_o,
  b64_stream_if.source                     out_o
);
  import b64_pkg::*;

  logic [LineLenWidth-1:0] pos_q, pos_d, pos_inc;
  logic                    jw_q, jw_d;
  logic                    nl_q, nl_d;
  logic [2:0]              idx_q, idx_d;
  logic                    out_valid_q;
  out_item_t               out_q;
  logic                    slot_free, step_en, wrap, emit, last, done;
  logic [7:0]              ch;

  assign slot_free = !out_valid_q || out_o.ready;
  assign step_en   = job_valid_i && slot_free;
  assign pos_inc   = pos_q + LineLenWidth'(1);
  assign wrap      = (line_len_i != '0) && (pos_inc >= line_len_i);

  always_comb begin
    pos_d = pos_q;
    jw_d  = jw_q;
    nl_d  = nl_q;
    idx_d = idx_q;
    emit  = 1'b0;
    ch    = CharNl;
    last  = 1'b0;
    done  = 1'b0;
    if (step_en) begin
      priority if (nl_q) begin
        // Wrap newline; it ends the item once every character has gone out.
        emit = 1'b1;
        nl_d = 1'b0;
        last = (idx_q == job_i.count);
        done = last;
      end else if (idx_q < job_i.count) begin
        emit  = 1'b1;
        ch    = job_i.chars[idx_q[1:0]];
        idx_d = idx_q + 3'd1;
        if (wrap) begin
          pos_d = '0;
          nl_d  = 1'b1;
          jw_d  = 1'b1;
        end else begin
          pos_d = pos_inc;
          jw_d  = 1'b0;
        end
        last = (idx_d == job_i.count) && !wrap && !job_i.closes_msg;
        done = last;
      end else begin
        // Closing newline, left out when the output already ends on a wrap.
        emit = !jw_q;
        last = 1'b1;
        done = 1'b1;
      end
      if (done) begin
        idx_d = 3'd0;
        if (job_i.closes_msg) begin
          pos_d = '0;
          jw_d  = 1'b0;
        end
      end
    end
  end

  assign pop_o         = done;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      jw_q        <= 1'b0;
      nl_q        <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      jw_q  <= jw_d;
      nl_q  <= nl_d;
      idx_q <= idx_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && emit) begin
      out_q.character   <= ch;
      out_q.last_of_run <= last;
    end
  end

endmodule

// ===== hdl/base64_stream_encoder_core.sv =====
// Channel  Direction  Payload                      Accepted when
// in_i     sink       action, data_byte            in_i.valid && in_i.ready
// out_o    source     character, last_of_run       out_o.valid && out_o.ready
// cfg_i    sink       line_length                  cfg_i.valid (ready is always high)
//
// An item is registered as a list of up to four characters; the line formatter
// then sends one character or newline per cycle while the output is not stalled.
// An end of message may yield no character at all.
// Reset clears the group and line state and sets the line length to 64.
// A stalled output holds the formatter, which holds the next item at the input.
module base64_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64_stream_if.sink   in_i,
  b64_stream_if.source out_o,
  b64_stream_if.sink   cfg_i
);
  import b64_pkg::*;

  logic [LineLenWidth-1:0] line_len_q;
  job_t                    job;
  logic                    job_valid;
  logic                    pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= LineLenWidth'(64);
    end else if (cfg_i.valid) begin
      line_len_q <= cfg_i.payload.line_length;
    end
  end

  b64_group_enc u_group_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_i       (pop),
    .job_o       (job),
    .job_valid_o (job_valid)
  );

  b64_line_fmt u_line_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .line_len_i  (line_len_q),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== dv/b64_encode_check.sv =====
`timescale 1ns / 100ps

module b64_encode_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  b64_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  b64_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  b64_pkg::cfg_item_t cfg_item_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  import b64_pkg::*;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [LineLenWidth-1:0] line_len;
  logic [1:0]              grp_phase;
  logic [3:0]              carry_bits;
  logic [LineLenWidth-1:0] col;
  logic                    wrapped;

  out_item_t expected_chars[$];
  out_item_t item_chars[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic void put_raw(logic [7:0] ch);
    item_chars.push_back('{character: ch, last_of_run: 1'b0});
  endfunction

  // The column counter wraps at ten bits even when line wrapping is off.
  function automatic void put_char(logic [7:0] ch);
    put_raw(ch);
    wrapped = 1'b0;
    col = col + LineLenWidth'(1);
    if (line_len != '0 && col >= line_len) begin
      put_raw(CharNl);
      col = '0;
      wrapped = 1'b1;
    end
  endfunction

  function automatic void put_sextet(logic [5:0] v);
    put_char(8'(alphabet[int'(v)]));
  endfunction

  function automatic void take_byte(logic [7:0] b);
    case (grp_phase)
      2'd0: begin
        put_sextet(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        grp_phase = 2'd1;
      end
      2'd1: begin
        put_sextet({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        grp_phase = 2'd2;
      end
      default: begin
        put_sextet({carry_bits, b[7:6]});
        put_sextet(b[5:0]);
        carry_bits = '0;
        grp_phase = 2'd0;
      end
    endcase
  endfunction

  function automatic void close_message();
    if (grp_phase == 2'd1) begin
      put_sextet({carry_bits[1:0], 4'b0000});
      put_char(CharPad);
      put_char(CharPad);
    end else if (grp_phase == 2'd2) begin
      put_sextet({carry_bits, 2'b00});
      put_char(CharPad);
    end
    // A message that already ends on a wrap gets no second newline.
    if (!wrapped) begin
      put_raw(CharNl);
    end
    grp_phase = '0;
    carry_bits = '0;
    col = '0;
    wrapped = 1'b0;
  endfunction

  function automatic void predict_chars(in_item_t it);
    item_chars.delete();
    case (it.action)
      ActData: begin
        take_byte(it.data_byte);
      end
      ActLast: begin
        take_byte(it.data_byte);
        close_message();
      end
      ActEnd: begin
        close_message();
      end
      default: begin
      end
    endcase
    if (item_chars.size() > 0) begin
      item_chars[item_chars.size() - 1].last_of_run = 1'b1;
    end
    foreach (item_chars[i]) begin
      expected_chars.push_back(item_chars[i]);
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      line_len   = LineLenWidth'(64);
      grp_phase  = '0;
      carry_bits = '0;
      col        = '0;
      wrapped    = 1'b0;
      expected_chars.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        line_len = cfg_item_i.line_length;
      end
      if (in_valid_i && in_ready_i) begin
        predict_chars(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("unexpected character 0x%02h last %0b",
                                 out_item_i.character, out_item_i.last_of_run));
        end else begin
          want = expected_chars.pop_front();
          checked_o++;
          if (out_item_i.character !== want.character) begin
            note_failure($sformatf("character: expected 0x%02h, got 0x%02h",
                                   want.character, out_item_i.character));
          end
          if (out_item_i.last_of_run !== want.last_of_run) begin
            note_failure($sformatf("last_of_run on 0x%02h: expected %0b, got %0b",
                                   want.character, want.last_of_run,
                                   out_item_i.last_of_run));
          end
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import b64_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int unsigned HoldCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  b64_stream_if #(.payload_t(in_item_t))  in_ch ();
  b64_stream_if #(.payload_t(out_item_t)) out_ch ();
  b64_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_sent = 0;
  logic        stall_req = 1'b0;
  int unsigned hold_left = 0;

  base64_stream_encoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  b64_encode_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_item_i    (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_item_i   (out_ch.payload),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_item_i   (cfg_ch.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (stall_req) begin
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] act, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{action: act, data_byte: b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act != ActUnused) begin
      items_sent++;
    end
  endtask

  // Leaves the input quiet until every predicted character has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_line_len(logic [LineLenWidth-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{line_length: len};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly whole messages; now and then an ignored item or an unterminated run.
  task automatic send_message();
    int unsigned len;
    logic        closed;
    closed = 1'b0;
    if ($urandom_range(9) == 0) begin
      send_item(ActUnused, 8'($urandom));
    end
    len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len - 1 && $urandom_range(1) == 1) begin
        send_item(ActLast, 8'($urandom));
        closed = 1'b1;
      end else begin
        send_item(ActData, 8'($urandom));
      end
    end
    if (!closed && $urandom_range(9) != 0) begin
      send_item(ActEnd, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    logic [LineLenWidth-1:0] len_tab[4];
    int unsigned phase_start;

    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default line length straight after reset.
    send_item(ActEnd, 8'h00);
    send_item(ActLast, 8'h00);
    send_item(ActData, 8'hFF);
    send_item(ActLast, 8'hFF);
    send_item(ActData, 8'h4D);
    send_item(ActData, 8'h61);
    send_item(ActLast, 8'h6E);
    send_item(ActData, 8'hFF);
    send_item(ActData, 8'h00);
    send_item(ActData, 8'hAA);
    send_item(ActEnd, 8'hFF);
    send_item(ActUnused, 8'h5A);
    send_item(ActData, 8'h01);
    send_item(ActEnd, 8'h00);
    send_item(ActData, 8'h12);
    send_item(ActData, 8'h34);
    send_item(ActEnd, 8'h00);
    wait_idle();

    // A line of one character wraps after every character, so no closing newline.
    write_line_len(LineLenWidth'(1));
    send_item(ActData, 8'h55);
    send_item(ActLast, 8'hAA);
    wait_idle();

    // Lower the line length part way through a line.
    write_line_len(LineLenWidth'(1023));
    send_item(ActData, 8'hC3);
    send_item(ActData, 8'h3C);
    send_item(ActData, 8'h96);
    wait_idle();
    write_line_len(LineLenWidth'(2));
    send_item(ActData, 8'h69);
    send_item(ActLast, 8'h0F);
    wait_idle();

    // With wrapping off the column still counts, so a shorter line wraps at once.
    write_line_len('0);
    repeat (6) send_item(ActData, 8'($urandom));
    wait_idle();
    write_line_len(LineLenWidth'(4));
    send_item(ActData, 8'($urandom));
    send_item(ActLast, 8'($urandom));
    wait_idle();

    idle_tab  = '{0, 81, 0, 26};
    stall_tab = '{0, 0, 81, 26};
    len_tab   = '{'0, LineLenWidth'(3), LineLenWidth'($urandom_range(1, 20)),
                  LineLenWidth'(1023)};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      write_line_len(len_tab[p]);
      if (p == 0) begin
        // Hold the output back while items keep coming, so the input backs up.
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 15) send_message();
      wait_idle();
    end

    write_line_len(LineLenWidth'($urandom_range(1, 1023)));
    send_idle_pct = 0;
    sink_stall_pct = 0;
    phase_start = items_sent;
    while (items_sent - phase_start < 8) send_message();
    send_item(ActEnd, 8'h00);
    wait_idle();

    $display("Sent %0d message items under line lengths from 0 to 1023 and four idling mixes.",
             items_sent);
    $display("Compared %0d output characters with the prediction.", checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("Timed out waiting for the encoder.");
    $display("Some tests failed");
    $finish;
  end

endmodule
